// ===== hdl/fcull_pkg.sv =====
// Package for the frustum cull test block: widths, the command codes and
// the item record that walks down the chain of plane cells.
// No dependencies; used by fcull_cell and frustum_cull_test.
package fcull_pkg;

   // Number of plane cells in the chain.
   localparam int NUM_PLANES = 6;
   // Stored width of coordinates and normals.
   localparam int COORD_WIDTH = 24;
   // Width of each coordinate field on the stream.
   localparam int IN_WIDTH = 24;
   // Coordinates keep the low bits that fit both widths.
   localparam int EFF_WIDTH = (COORD_WIDTH < IN_WIDTH) ? COORD_WIDTH : IN_WIDTH;

   localparam int CMD_WIDTH    = 2;
   localparam int IDX_WIDTH    = 3;
   localparam int RADIUS_WIDTH = 23;
   // Radius is scaled by 256 to line up with the 16 fraction bits of a distance.
   localparam int RADIUS_SHIFT = 8;

   // Difference of two coordinates, then normal times difference.
   localparam int DIFF_WIDTH = EFF_WIDTH + 1;
   localparam int PROD_WIDTH = EFF_WIDTH + DIFF_WIDTH;
   // Sum of three products plus the scaled radius, with a sign bit to spare.
   localparam int SUM3_WIDTH = PROD_WIDTH + 2;
   localparam int RAD_EXT_WIDTH = RADIUS_WIDTH + RADIUS_SHIFT + 1;
   localparam int DIST_WIDTH = ((SUM3_WIDTH > RAD_EXT_WIDTH) ? SUM3_WIDTH : RAD_EXT_WIDTH) + 1;

   // Stream widths, rounded up to whole bytes.
   localparam int REQ_BITS  = CMD_WIDTH + IDX_WIDTH + 6 * IN_WIDTH + RADIUS_WIDTH;
   localparam int REQ_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_WIDTH = 8;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_POINT  = 2'd1,
      CMD_SPHERE = 2'd2,
      CMD_BOX    = 2'd3
   } cmd_type;

   typedef logic [2:0][EFF_WIDTH-1:0] coord_vec_type;

   // One item as it travels from cell to cell.
   typedef struct packed {
      cmd_type                 cmd;
      logic [IDX_WIDTH-1:0]    idx;
      coord_vec_type           a;
      coord_vec_type           b;
      logic [RADIUS_WIDTH-1:0] radius;
      logic                    visible;
   } item_type;

endpackage

// ===== hdl/fcull_cell.sv =====
// One plane cell of the frustum cull chain: holds one plane, computes the
// signed distance of each passing item and clears its visible flag if culled.
// Depends on fcull_pkg.
module fcull_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fcull_pkg::IDX_WIDTH-1:0] cell_index,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  fcull_pkg::item_type             in_item,
   output logic                            out_valid,
   input  logic                            out_ready,
   output fcull_pkg::item_type             out_item
);

   // Plane held by this cell.
   fcull_pkg::coord_vec_type point_ff, point_in;
   fcull_pkg::coord_vec_type normal_ff, normal_in;

   // Product stage.
   logic                                         a_valid_ff, a_valid_in;
   fcull_pkg::item_type                          a_item_ff;
   logic signed [2:0][fcull_pkg::PROD_WIDTH-1:0] a_prod_ff, a_prod_in;

   // Compare stage, which is the hand-off register to the next cell.
   logic                b_valid_ff, b_valid_in;
   fcull_pkg::item_type b_item_ff, b_item_in;

   logic a_ready;
   logic b_ready;
   logic take_in;
   logic a_to_b;

   logic signed [fcull_pkg::EFF_WIDTH-1:0]  vert   [3];
   logic signed [fcull_pkg::EFF_WIDTH-1:0]  pt     [3];
   logic signed [fcull_pkg::EFF_WIDTH-1:0]  nrm    [3];
   logic signed [fcull_pkg::DIFF_WIDTH-1:0] diff   [3];
   logic signed [fcull_pkg::DIST_WIDTH-1:0] dist_sum;
   logic        [fcull_pkg::DIST_WIDTH-1:0] rad_term;

   // Backpressure: a stage moves when it is empty or its successor moves.
   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;
   assign take_in  = in_valid && a_ready;
   assign a_to_b   = a_valid_ff && b_ready;

   // Plane load: a load addressed to this cell replaces the stored plane.
   always_comb begin
      point_in  = point_ff;
      normal_in = normal_ff;
      if (take_in && in_item.cmd == fcull_pkg::CMD_LOAD && in_item.idx == cell_index) begin
         point_in  = in_item.a;
         normal_in = in_item.b;
      end
   end

   // Vertex selection, difference to the plane point and the three products.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pt[k]  = $signed(point_ff[k]);
         nrm[k] = $signed(normal_ff[k]);
         // A box uses its maximum on axes where the normal is zero or more.
         if (in_item.cmd == fcull_pkg::CMD_BOX && !normal_ff[k][fcull_pkg::EFF_WIDTH-1]) begin
            vert[k] = $signed(in_item.b[k]);
         end else begin
            vert[k] = $signed(in_item.a[k]);
         end
         diff[k] = fcull_pkg::DIFF_WIDTH'(vert[k]) - fcull_pkg::DIFF_WIDTH'(pt[k]);
         a_prod_in[k] = fcull_pkg::PROD_WIDTH'(nrm[k]) * fcull_pkg::PROD_WIDTH'(diff[k]);
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (take_in) begin
         a_valid_in = 1'b1;
      end else if (a_to_b) begin
         a_valid_in = 1'b0;
      end
   end

   // Sum of products plus the scaled sphere radius; a negative sum culls.
   always_comb begin
      rad_term = '0;
      if (a_item_ff.cmd == fcull_pkg::CMD_SPHERE) begin
         rad_term = fcull_pkg::DIST_WIDTH'({a_item_ff.radius, {fcull_pkg::RADIUS_SHIFT{1'b0}}});
      end
      dist_sum = fcull_pkg::DIST_WIDTH'($signed(a_prod_ff[0]))
               + fcull_pkg::DIST_WIDTH'($signed(a_prod_ff[1]))
               + fcull_pkg::DIST_WIDTH'($signed(a_prod_ff[2])) + $signed(rad_term);
      b_item_in = a_item_ff;
      if (a_item_ff.cmd != fcull_pkg::CMD_LOAD && dist_sum[fcull_pkg::DIST_WIDTH-1]) begin
         b_item_in.visible = 1'b0;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (a_to_b) begin
         b_valid_in = 1'b1;
      end else if (out_ready) begin
         b_valid_in = 1'b0;
      end
   end

   // Control state and the plane itself clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         point_ff   <= '0;
         normal_ff  <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         point_ff   <= point_in;
         normal_ff  <= normal_in;
      end
   end

   // Payload registers load on each transfer into their stage.
   always_ff @(posedge clock) begin
      if (take_in) begin
         a_item_ff <= in_item;
         a_prod_ff <= a_prod_in;
      end
      if (a_to_b) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ===== hdl/frustum_cull_test.sv =====
// Top level of the frustum cull test: unpacks request transfers, runs them
// down a chain of plane cells and registers the visible bit for the result.
// Depends on fcull_pkg and fcull_cell.
//
//   Channel | Direction | Carries
//   req_    | in        | load plane or test point / sphere / box
//   rsp_    | out       | visible bit, one per test, none per load
//
// Every item passes NUM_PLANES cells of two register stages each and then
// the output register. One item enters per cycle while no stalled result
// has backed the chain up to the input.
// Loads travel the chain in order, so a test sees exactly the loads before it.
// Reset clears all planes to zero, which culls nothing, and empties the chain.
// A stalled result holds the chain only as far back as it has no empty stage.
module frustum_cull_test (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command[1:0], plane_index[4:2], a_x[28:5], a_y[52:29], a_z[76:53],
   // b_x[100:77], b_y[124:101], b_z[148:125], radius[171:149], zero fill above
   input  logic [fcull_pkg::REQ_WIDTH-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // visible[0], zero fill above
   output logic [fcull_pkg::RSP_WIDTH-1:0] rsp_tdata
);

   localparam int IW = fcull_pkg::IN_WIDTH;
   localparam int F0 = fcull_pkg::CMD_WIDTH + fcull_pkg::IDX_WIDTH;

   logic                link_valid [fcull_pkg::NUM_PLANES+1];
   logic                link_ready [fcull_pkg::NUM_PLANES+1];
   fcull_pkg::item_type link_item  [fcull_pkg::NUM_PLANES+1];

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_visible_ff;
   logic last_take;

   // Unpack a request; coordinates keep their low stored bits.
   always_comb begin
      link_item[0].cmd = fcull_pkg::cmd_type'(req_tdata[fcull_pkg::CMD_WIDTH-1:0]);
      link_item[0].idx = req_tdata[F0-1:fcull_pkg::CMD_WIDTH];
      for (int k = 0; k < 3; k++) begin
         link_item[0].a[k] = req_tdata[F0 + k*IW +: fcull_pkg::EFF_WIDTH];
         link_item[0].b[k] = req_tdata[F0 + (k+3)*IW +: fcull_pkg::EFF_WIDTH];
      end
      link_item[0].radius  = req_tdata[F0 + 6*IW +: fcull_pkg::RADIUS_WIDTH];
      link_item[0].visible = 1'b1;
   end

   assign link_valid[0] = req_tvalid;
   assign req_tready    = link_ready[0];

   // Chain of plane cells, cell i holding plane i.
   for (genvar i = 0; i < fcull_pkg::NUM_PLANES; i++) begin : g_cell
      fcull_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (fcull_pkg::IDX_WIDTH'(i)),
         .in_valid   (link_valid[i]),
         .in_ready   (link_ready[i]),
         .in_item    (link_item[i]),
         .out_valid  (link_valid[i+1]),
         .out_ready  (link_ready[i+1]),
         .out_item   (link_item[i+1])
      );
   end

   // Output register: tests become results, loads end here.
   assign link_ready[fcull_pkg::NUM_PLANES] = !rsp_valid_ff || rsp_tready;
   assign last_take = link_valid[fcull_pkg::NUM_PLANES] && link_ready[fcull_pkg::NUM_PLANES];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (last_take) begin
         rsp_valid_in = (link_item[fcull_pkg::NUM_PLANES].cmd != fcull_pkg::CMD_LOAD);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_take) begin
         rsp_visible_ff <= link_item[fcull_pkg::NUM_PLANES].visible;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(fcull_pkg::RSP_WIDTH-1){1'b0}}, rsp_visible_ff};

endmodule
